// ----- sv/multi_channel_window_mean_macros.svh -----
// Assertion shorthands used by the checker file.
`ifndef MULTI_CHANNEL_WINDOW_MEAN_MACROS_SVH
`define MULTI_CHANNEL_WINDOW_MEAN_MACROS_SVH

// Same-cycle implication, sampled on clk and silent while rst_n is low.
`define CMWM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and silent while rst_n is low.
`define CMWM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cmwm_pkg.sv -----
package cmwm_pkg;

    localparam int CHANNELS_DEF   = 96;
    localparam int WINDOW_MAX_DEF = 64;

    localparam int CH_W    = 7;
    localparam int PWR_W   = 32;
    localparam int LEN_W   = 7;
    localparam int WSLOT_W = 6;
    localparam int SUM_W   = 38;
    localparam int DATA_W  = 40;

    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [LEN_W-1:0] len_t;

    localparam len_t LEN_RESET = 7'd16;
    localparam len_t LEN_MIN   = 7'd2;
    localparam sum_t SUM_MAX   = {SUM_W{1'b1}};

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- sv/cmwm_div.sv -----
module cmwm_div
    import cmwm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  sum_t      dividend,
    input  len_t      divisor,
    output sum_t      quotient,
    output div_stat_t stat
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    sum_t             quo_reg;
    len_t             rem_reg;
    len_t             dvs_reg;
    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   trial_diff;
    logic             fits;
    len_t             rem_step;

    // Restoring division, one quotient bit per cycle; the dividend shifts out of
    // the top of quo_reg while quotient bits shift in at the bottom.
    assign trial      = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_diff = trial - {1'b0, dvs_reg};
    assign fits       = (trial >= {1'b0, dvs_reg});
    assign rem_step   = fits ? trial_diff[LEN_W-1:0] : trial[LEN_W-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= rem_step;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- sv/multi_channel_window_mean.sv -----
// Per-channel sliding-window mean of noise power.
// Input stream (s_*): one word per channel reading; s_tlast marks the last
// channel of an event, after which the shared window slot advances.
// Output stream (m_*): one word per in-range channel with the updated mean;
// m_tuser is high once the window has wrapped at least once.
// Configuration (cfg_*): window length, always ready; write it only while idle.
// s_tready is low while a word is in work, so the next word waits until the
// sequencer is back in idle. A word passes the accept, memory read, subtract
// and add steps, the 38-step serial divider that forms sum / length, the
// divider finish and the output load.
// A word with a channel outside the range is taken but gives no output word.
// A finished result waits in the output register while m_tready is low; the
// sequencer holds its next result until that register frees up.
// Reset clears the running sums (per-channel valid bits), the window slot, the
// full flag and sets the window length to 16. Sample memory is not cleared.
module multi_channel_window_mean
    import cmwm_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,  // [6:0] channel, [38:7] power, [39] zero
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,  // [6:0] channel_out, [38:7] mean_power, [39] zero
    output logic              m_tuser,  // [0] window_full
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LEN_W-1:0]  cfg_data
);

    localparam int STORE_DEPTH = CHANNELS * WINDOW_MAX;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int SLOT_W      = $clog2(WINDOW_MAX);
    localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PAD_W       = DATA_W - CH_W - PWR_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_SUB  = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    len_t                cfg_len_reg;
    logic [WSLOT_W-1:0]  write_slot_reg;
    logic [WSLOT_W-1:0]  write_slot_next;
    logic [SLOT_W-1:0]   slot_mod_reg;
    logic [SLOT_W-1:0]   slot_mod_next;
    logic                full_reg;
    logic [CHANNELS-1:0] sum_valid_reg;

    logic [CH_W-1:0]     item_ch_reg;
    logic [PWR_W-1:0]    item_pwr_reg;
    logic [SLOT_W-1:0]   item_slot_reg;
    logic                item_full_reg;
    len_t                item_len_reg;

    logic [PWR_W-1:0]    sample_q_reg;
    sum_t                sum_q_reg;
    sum_t                diff_reg;

    logic                out_valid_reg;
    logic [CH_W-1:0]     out_ch_reg;
    logic [PWR_W-1:0]    out_mean_reg;
    logic                out_full_reg;

    logic [PWR_W-1:0]    sample_mem [STORE_DEPTH];
    sum_t                sum_mem [CHANNELS];

    logic                in_acc;
    logic [CH_W-1:0]     in_ch;
    logic                in_ch_ok;
    len_t                eff_len;
    logic [WSLOT_W:0]    slot_inc;
    logic                wrap;
    logic [ADDR_W-1:0]   store_addr;
    logic [CH_IDX_W-1:0] ch_idx;
    sum_t                sum_eff;
    sum_t                old_sample;
    sum_t                diff;
    logic [SUM_W:0]      total;
    sum_t                new_sum;
    logic                div_start;
    sum_t                div_quo;
    div_stat_t           div_stat;
    logic [PWR_W-1:0]    mean_sat;
    logic                out_load;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) && !div_stat.busy;
    assign in_acc    = s_tvalid && s_tready;
    assign in_ch     = s_tdata[CH_W-1:0];
    assign in_ch_ok  = (32'(in_ch) < CHANNELS);

    // Out-of-range lengths are clamped to the supported span.
    always_comb
    begin
        if (cfg_len_reg < LEN_MIN)
            eff_len = LEN_MIN;
        else if (32'(cfg_len_reg) > WINDOW_MAX)
            eff_len = LEN_W'(WINDOW_MAX);
        else
            eff_len = cfg_len_reg;
    end

    // slot_mod_reg tracks write_slot modulo WINDOW_MAX; the slot counter only
    // steps by one or returns to zero, so no divider is needed.
    assign slot_inc        = {1'b0, write_slot_reg} + (WSLOT_W + 1)'(1);
    assign wrap            = (slot_inc >= (WSLOT_W + 1)'(eff_len));
    assign write_slot_next = wrap ? '0 : slot_inc[WSLOT_W-1:0];

    always_comb
    begin
        if (wrap || (write_slot_reg == {WSLOT_W{1'b1}}))
            slot_mod_next = '0;
        else if ((32'(slot_mod_reg) + 32'd1) == WINDOW_MAX)
            slot_mod_next = '0;
        else
            slot_mod_next = slot_mod_reg + SLOT_W'(1);
    end

    assign store_addr = ADDR_W'(32'(item_ch_reg) * WINDOW_MAX + 32'(item_slot_reg));
    assign ch_idx     = CH_IDX_W'(item_ch_reg);

    // A channel never written since reset reads as an empty sum.
    assign sum_eff    = sum_valid_reg[ch_idx] ? sum_q_reg : '0;
    assign old_sample = item_full_reg ? SUM_W'(sample_q_reg) : '0;
    assign diff       = (sum_eff >= old_sample) ? (sum_eff - old_sample) : '0;
    assign total      = {1'b0, diff_reg} + (SUM_W + 1)'(item_pwr_reg);
    assign new_sum    = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
    assign div_start  = (state_reg == ST_ADD);

    assign mean_sat = (|div_quo[SUM_W-1:PWR_W]) ? {PWR_W{1'b1}} : div_quo[PWR_W-1:0];
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_ch_ok)
                    state_next = ST_READ;
            end
            ST_READ: state_next = ST_SUB;
            ST_SUB:  state_next = ST_ADD;
            ST_ADD:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cfg_len_reg    <= LEN_RESET;
            write_slot_reg <= '0;
            slot_mod_reg   <= '0;
            full_reg       <= 1'b0;
            sum_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                cfg_len_reg <= cfg_data;
            if (in_acc && s_tlast)
            begin
                write_slot_reg <= write_slot_next;
                slot_mod_reg   <= slot_mod_next;
                full_reg       <= full_reg | wrap;
            end
            if (state_reg == ST_ADD)
                sum_valid_reg[ch_idx] <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // The word keeps the slot, full flag and length as they stood when taken.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            item_ch_reg   <= in_ch;
            item_pwr_reg  <= s_tdata[CH_W +: PWR_W];
            item_slot_reg <= slot_mod_reg;
            item_full_reg <= full_reg;
            item_len_reg  <= eff_len;
        end
        if (state_reg == ST_SUB)
            diff_reg <= diff;
        if (out_load)
        begin
            out_ch_reg   <= item_ch_reg;
            out_mean_reg <= mean_sat;
            out_full_reg <= item_full_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
            sample_q_reg <= sample_mem[store_addr];
        if (state_reg == ST_ADD)
            sample_mem[store_addr] <= item_pwr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
            sum_q_reg <= sum_mem[ch_idx];
        if (state_reg == ST_ADD)
            sum_mem[ch_idx] <= new_sum;
    end

    cmwm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (new_sum),
        .divisor  (item_len_reg),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_mean_reg, out_ch_reg};
    assign m_tuser  = out_full_reg;

endmodule

// ----- sv/cmwm_check.sv -----
`include "multi_channel_window_mean_macros.svh"

module cmwm_check
    import cmwm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [DATA_W-1:0] s_tdata,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic              m_tuser
);

    logic seen_full_reg;

    // Once a delivered word reported a full window, every later word must too.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_full_reg <= 1'b0;
        else if (m_tvalid && m_tready && m_tuser)
            seen_full_reg <= 1'b1;
    end

    `CMWM_ASSERT_NXT(a_busy_after_accept,
        s_tvalid && s_tready && (32'(s_tdata[CH_W-1:0]) < CHANNELS), !s_tready,
        "input still ready after taking an in-range word")
    `CMWM_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser),
        "stalled output word changed or dropped")
    `CMWM_ASSERT_IMP(a_out_channel, m_tvalid, 32'(m_tdata[CH_W-1:0]) < CHANNELS,
        "output word for a channel outside the range")
    `CMWM_ASSERT_IMP(a_full_sticky, m_tvalid && seen_full_reg, m_tuser,
        "window full flag dropped after it was reported")

endmodule

bind multi_channel_window_mean cmwm_check #(.CHANNELS(CHANNELS)) u_cmwm_check (.*);
